@@ design/dtxt_pkg.sv @@
// ============================================================================
// DNS-SD TXT record parser package
// Field widths, byte kind codes, error codes and limits shared by the parser
// and its channel interfaces.
// ============================================================================
`default_nettype none

package dtxt_pkg;

  // Field widths of the input and result transactions.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned CountW  = 9;
  localparam int unsigned ErrW    = 2;

  // Highest number of pairs accepted in one blob.
  localparam int unsigned MaxPairs = 256;

  // The character that ends a key.
  localparam logic [ByteW-1:0] SepChar = 8'h3D;

  // Byte classification codes.
  localparam logic [KindW-1:0] KIND_LEN = 3'd0;
  localparam logic [KindW-1:0] KIND_KEY = 3'd1;
  localparam logic [KindW-1:0] KIND_SEP = 3'd2;
  localparam logic [KindW-1:0] KIND_VAL = 3'd3;
  localparam logic [KindW-1:0] KIND_IGN = 3'd4;

  // Sticky error codes.
  localparam logic [ErrW-1:0] ERR_NONE      = 2'd0;
  localparam logic [ErrW-1:0] ERR_NO_SEP    = 2'd1;
  localparam logic [ErrW-1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [ErrW-1:0] ERR_TOO_MANY  = 2'd3;

endpackage

`default_nettype wire

@@ design/dtxt_in_if.sv @@
// ============================================================================
// DNS-SD TXT record parser input channel
// One blob byte per transaction, with a flag on the final byte.
// ============================================================================
`default_nettype none

interface dtxt_in_if;
  logic                         valid;
  logic                         ready;
  logic [dtxt_pkg::ByteW-1:0]   data_byte;
  logic                         last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ design/dtxt_out_if.sv @@
// ============================================================================
// DNS-SD TXT record parser result channel
// One classified byte per transaction, with pair and blob summaries.
// ============================================================================
`default_nettype none

interface dtxt_out_if;
  logic                         valid;
  logic                         ready;
  logic [dtxt_pkg::KindW-1:0]   byte_kind;
  logic [dtxt_pkg::ByteW-1:0]   part_offset;
  logic [dtxt_pkg::ByteW-1:0]   pair_index;
  logic                         pair_done;
  logic [dtxt_pkg::ByteW-1:0]   key_length;
  logic [dtxt_pkg::ByteW-1:0]   value_length;
  logic                         blob_done;
  logic [dtxt_pkg::CountW-1:0]  pair_count;
  logic [dtxt_pkg::ErrW-1:0]    error_code;

  modport source (
    output valid, output byte_kind, output part_offset, output pair_index,
    output pair_done, output key_length, output value_length, output blob_done,
    output pair_count, output error_code, input ready
  );
  modport sink (
    input valid, input byte_kind, input part_offset, input pair_index,
    input pair_done, input key_length, input value_length, input blob_done,
    input pair_count, input error_code, output ready
  );
endinterface

`default_nettype wire

@@ design/dns_txt_record_parser.sv @@
// ============================================================================
// DNS-SD TXT record key/value parser
// Classifies each byte of a TXT record blob and reports key and value
// lengths at the end of every well-formed pair, with a sticky error code.
// ============================================================================
//
//   Channel  Direction  Transaction
//   in_i     sink       one blob byte (data_byte, last_byte)
//   out_o    source     one classified byte with pair and blob status
//
// One byte per cycle is sustained while out_o takes results; each transaction
// gives exactly one result. A byte is held in the input register, classified by
// the parse logic and written to the result register, which drives out_o. The
// input register takes one more byte while a finished result waits. Reset
// clears the parse state to the start of a blob. A stall on out_o holds the
// result register and, once the input register is also full, deasserts
// in_i.ready.
//
`default_nettype none

module dns_txt_record_parser (
  input  wire        clk_i,
  input  wire        rst_ni,
  dtxt_in_if.sink    in_i,
  dtxt_out_if.source out_o
);

  localparam int unsigned ByteW  = dtxt_pkg::ByteW;
  localparam int unsigned CountW = dtxt_pkg::CountW;

  // Parse phase codes.
  localparam logic [1:0] PH_LEN = 2'd0;
  localparam logic [1:0] PH_KEY = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;
  localparam logic [1:0] PH_ERR = 2'd3;

  localparam logic [CountW-1:0] PairsSat = '1;

  // Input register.
  logic             in_valid_q;
  logic [ByteW-1:0] data_q;
  logic             last_q;

  // Parse state.
  logic [1:0]               phase_q, phase_d;
  logic [ByteW-1:0]         bytes_left_q, bytes_left_d;
  logic [ByteW-1:0]         key_cnt_q, key_cnt_d;
  logic [ByteW-1:0]         val_cnt_q, val_cnt_d;
  logic [CountW-1:0]        pairs_q, pairs_d;
  logic [dtxt_pkg::ErrW-1:0] err_q, err_d;
  logic                     first_q, first_d;

  // Result register.
  logic                      out_valid_q;
  logic [dtxt_pkg::KindW-1:0] kind_q, kind_d;
  logic [ByteW-1:0]          offset_q, offset_d;
  logic [ByteW-1:0]          index_q;
  logic                      done_q, done_d;
  logic [ByteW-1:0]          klen_q, klen_d;
  logic [ByteW-1:0]          vlen_q, vlen_d;
  logic                      blob_q;
  logic [CountW-1:0]         count_q, count_d;
  logic [dtxt_pkg::ErrW-1:0] code_q, code_d;

  logic             advance;
  logic             process;
  logic             single;
  logic [ByteW-1:0] left_dec;

  assign advance    = !out_valid_q || out_o.ready;
  assign process    = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  // A blob made of one byte holds no pairs.
  assign single   = last_q && first_q;
  assign left_dec = bytes_left_q - ByteW'(1);

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    key_cnt_d    = key_cnt_q;
    val_cnt_d    = val_cnt_q;
    pairs_d      = pairs_q;
    err_d        = err_q;
    first_d      = 1'b0;
    kind_d       = dtxt_pkg::KIND_IGN;
    offset_d     = '0;
    done_d       = 1'b0;
    klen_d       = '0;
    vlen_d       = '0;

    case (phase_q)
      PH_LEN: begin
        kind_d = dtxt_pkg::KIND_LEN;
        if (!single) begin
          if (32'(pairs_q) >= dtxt_pkg::MaxPairs) begin
            if (err_d == dtxt_pkg::ERR_NONE) err_d = dtxt_pkg::ERR_TOO_MANY;
            phase_d = PH_ERR;
          end else begin
            bytes_left_d = data_q;
            key_cnt_d    = '0;
            val_cnt_d    = '0;
            if (data_q == '0) begin
              if (err_d == dtxt_pkg::ERR_NONE) err_d = dtxt_pkg::ERR_NO_SEP;
              phase_d = PH_ERR;
            end else begin
              phase_d = PH_KEY;
            end
          end
        end
      end
      PH_KEY: begin
        bytes_left_d = left_dec;
        if (data_q == dtxt_pkg::SepChar) begin
          kind_d  = dtxt_pkg::KIND_SEP;
          phase_d = PH_VAL;
        end else begin
          kind_d    = dtxt_pkg::KIND_KEY;
          offset_d  = key_cnt_q;
          key_cnt_d = key_cnt_q + ByteW'(1);
          // The pair ran out before any separator was seen.
          if (left_dec == '0) begin
            if (err_d == dtxt_pkg::ERR_NONE) err_d = dtxt_pkg::ERR_NO_SEP;
            phase_d = PH_ERR;
          end
        end
      end
      PH_VAL: begin
        kind_d       = dtxt_pkg::KIND_VAL;
        offset_d     = val_cnt_q;
        val_cnt_d    = val_cnt_q + ByteW'(1);
        bytes_left_d = left_dec;
      end
      default: begin
      end
    endcase

    // A separator or value byte that uses up the pair length closes the pair.
    if (phase_d == PH_VAL && bytes_left_d == '0) begin
      done_d = 1'b1;
      klen_d = key_cnt_d;
      vlen_d = val_cnt_d;
      if (pairs_q < PairsSat) pairs_d = pairs_q + CountW'(1);
      phase_d = PH_LEN;
    end

    if (last_q && !single && phase_d != PH_LEN && phase_d != PH_ERR) begin
      if (err_d == dtxt_pkg::ERR_NONE) err_d = dtxt_pkg::ERR_TRUNCATED;
      phase_d = PH_ERR;
    end

    count_d = pairs_d;
    code_d  = err_d;

    // The end of a blob returns the parser to its start state.
    if (last_q) begin
      phase_d      = PH_LEN;
      bytes_left_d = '0;
      key_cnt_d    = '0;
      val_cnt_d    = '0;
      pairs_d      = '0;
      err_d        = dtxt_pkg::ERR_NONE;
      first_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_LEN;
      bytes_left_q <= '0;
      key_cnt_q    <= '0;
      val_cnt_q    <= '0;
      pairs_q      <= '0;
      err_q        <= dtxt_pkg::ERR_NONE;
      first_q      <= 1'b1;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (process) begin
        phase_q      <= phase_d;
        bytes_left_q <= bytes_left_d;
        key_cnt_q    <= key_cnt_d;
        val_cnt_q    <= val_cnt_d;
        pairs_q      <= pairs_d;
        err_q        <= err_d;
        first_q      <= first_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      data_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
    if (process) begin
      kind_q   <= kind_d;
      offset_q <= offset_d;
      index_q  <= pairs_q[ByteW-1:0];
      done_q   <= done_d;
      klen_q   <= klen_d;
      vlen_q   <= vlen_d;
      blob_q   <= last_q;
      count_q  <= count_d;
      code_q   <= code_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.byte_kind    = kind_q;
  assign out_o.part_offset  = offset_q;
  assign out_o.pair_index   = index_q;
  assign out_o.pair_done    = done_q;
  assign out_o.key_length   = klen_q;
  assign out_o.value_length = vlen_q;
  assign out_o.blob_done    = blob_q;
  assign out_o.pair_count   = count_q;
  assign out_o.error_code   = code_q;

`ifndef SYNTH
  // Once an error is recorded, the parser ignores bytes until the blob ends.
  a_err_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != dtxt_pkg::ERR_NONE |-> phase_q == PH_ERR)
    else $error("error recorded while still parsing");

  // Inside a pair, at least one byte of the blob has been consumed.
  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_KEY || phase_q == PH_VAL) |-> !first_q)
    else $error("blob start flag set inside a pair");

  // A completed pair never comes with an error.
  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> code_q == dtxt_pkg::ERR_NONE)
    else $error("pair completed under an error");

  // Ignored bytes only follow an error.
  a_ign_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == dtxt_pkg::KIND_IGN |-> code_q != dtxt_pkg::ERR_NONE)
    else $error("byte ignored without an error");
`endif

endmodule

`default_nettype wire

@@ bench/tb_dns_txt_record_parser.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Testbench for the DNS-SD TXT record parser
// Feeds TXT record blobs one byte per transaction and predicts each result
// transaction from a parse model kept in the bench. Covers one-byte blobs,
// well-formed pairs, each error case, the pair limit, output stalls and
// random blobs, with random idle gaps on both channels.
// ============================================================================

module tb_dns_txt_record_parser;

  localparam int unsigned ByteW  = dtxt_pkg::ByteW;
  localparam int unsigned KindW  = dtxt_pkg::KindW;
  localparam int unsigned CountW = dtxt_pkg::CountW;
  localparam int unsigned ErrW   = dtxt_pkg::ErrW;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomItems = 200;

  typedef enum logic [1:0] {PH_LEN, PH_KEY, PH_VAL, PH_ERR} parse_phase_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ByteW-1:0]  offset;
    logic [ByteW-1:0]  pair_idx;
    logic              done;
    logic [ByteW-1:0]  klen;
    logic [ByteW-1:0]  vlen;
    logic              blob_end;
    logic [CountW-1:0] count;
    logic [ErrW-1:0]   err;
  } byte_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dtxt_in_if  in_ch ();
  dtxt_out_if out_ch ();

  dns_txt_record_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Parse state of the bench's own model of the block.
  parse_phase_e      st_phase;
  logic [ByteW-1:0]  st_left;
  logic [ByteW-1:0]  st_keys;
  logic [ByteW-1:0]  st_vals;
  logic [CountW-1:0] st_pairs;
  logic [ErrW-1:0]   st_error;
  logic              st_first;

  byte_report_t report_q[$];
  byte_report_t want;
  logic [ByteW-1:0] blob_q[$];

  int unsigned err_count    = 0;
  int unsigned cycle_count  = 0;
  int unsigned parsed_items = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int hold_req   = 0;
  int hold_left  = 0;
  int stall_left = 0;

  function automatic void reset_parse_state();
    st_phase = PH_LEN;
    st_left  = '0;
    st_keys  = '0;
    st_vals  = '0;
    st_pairs = '0;
    st_error = dtxt_pkg::ERR_NONE;
    st_first = 1'b1;
  endfunction

  // The first error is kept; any error moves the parser to the ignore phase.
  function automatic void flag_error(input logic [ErrW-1:0] code);
    if (st_error == dtxt_pkg::ERR_NONE) st_error = code;
    st_phase = PH_ERR;
  endfunction

  function automatic byte_report_t classify_byte(input logic [ByteW-1:0] b,
                                                 input logic last);
    byte_report_t r;
    logic single;
    r = '0;
    r.kind = dtxt_pkg::KIND_IGN;
    r.pair_idx = st_pairs[ByteW-1:0];
    single = last && st_first;
    st_first = 1'b0;
    case (st_phase)
      PH_LEN: begin
        r.kind = dtxt_pkg::KIND_LEN;
        if (!single) begin
          if (32'(st_pairs) >= dtxt_pkg::MaxPairs) begin
            flag_error(dtxt_pkg::ERR_TOO_MANY);
          end else begin
            st_left = b;
            st_keys = '0;
            st_vals = '0;
            if (b == '0) flag_error(dtxt_pkg::ERR_NO_SEP);
            else st_phase = PH_KEY;
          end
        end
      end
      PH_KEY: begin
        st_left = st_left - ByteW'(1);
        if (b == dtxt_pkg::SepChar) begin
          r.kind = dtxt_pkg::KIND_SEP;
          st_phase = PH_VAL;
        end else begin
          r.kind = dtxt_pkg::KIND_KEY;
          r.offset = st_keys;
          st_keys = st_keys + ByteW'(1);
          if (st_left == '0) flag_error(dtxt_pkg::ERR_NO_SEP);
        end
      end
      PH_VAL: begin
        r.kind = dtxt_pkg::KIND_VAL;
        r.offset = st_vals;
        st_vals = st_vals + ByteW'(1);
        st_left = st_left - ByteW'(1);
      end
      default: ;
    endcase
    // A separator or value byte that uses up the pair length closes the pair.
    if (st_phase == PH_VAL && st_left == '0) begin
      r.done = 1'b1;
      r.klen = st_keys;
      r.vlen = st_vals;
      if (st_pairs != '1) st_pairs = st_pairs + CountW'(1);
      st_phase = PH_LEN;
    end
    if (last && !single && st_phase != PH_LEN && st_phase != PH_ERR)
      flag_error(dtxt_pkg::ERR_TRUNCATED);
    r.blob_end = last;
    r.count = st_pairs;
    r.err = st_error;
    if (last) reset_parse_state();
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_idle();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [ByteW-1:0] rand_key_byte();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(0, 255)); while (b == dtxt_pkg::SepChar);
    return b;
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int gap;
    byte_report_t r;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? pick_idle() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    r = classify_byte(b, last);
    report_q.push_back(r);
    if (r.kind != dtxt_pkg::KIND_IGN) parsed_items++;
  endtask

  task automatic send_blob();
    for (int i = 0; i < blob_q.size(); i++) send_byte(blob_q[i], i == blob_q.size() - 1);
    blob_q.delete();
  endtask

  // Appends one well-formed pair: length, key, separator, value.
  task automatic add_pair(input int klen, input int vlen);
    blob_q.push_back(ByteW'(klen + vlen + 1));
    repeat (klen) blob_q.push_back(rand_key_byte());
    blob_q.push_back(dtxt_pkg::SepChar);
    repeat (vlen) blob_q.push_back(ByteW'($urandom_range(0, 255)));
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_count++;
    end
  endtask

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = pick_idle() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (report_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        err_count++;
      end else begin
        want = report_q.pop_front();
        check_field("byte_kind", 16'(want.kind), 16'(out_ch.byte_kind));
        check_field("part_offset", 16'(want.offset), 16'(out_ch.part_offset));
        check_field("pair_index", 16'(want.pair_idx), 16'(out_ch.pair_index));
        check_field("pair_done", 16'(want.done), 16'(out_ch.pair_done));
        check_field("key_length", 16'(want.klen), 16'(out_ch.key_length));
        check_field("value_length", 16'(want.vlen), 16'(out_ch.value_length));
        check_field("blob_done", 16'(want.blob_end), 16'(out_ch.blob_done));
        check_field("pair_count", 16'(want.count), 16'(out_ch.pair_count));
        check_field("error_code", 16'(want.err), 16'(out_ch.error_code));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_single_byte_blobs();
    blob_q = '{8'h00};
    send_blob();
    blob_q = '{8'hFF};
    send_blob();
  endtask

  task automatic test_well_formed_pairs();
    // "a=b", then an empty key with an empty value, then an empty key
    // with extreme value bytes.
    blob_q = '{8'h03, 8'h61, dtxt_pkg::SepChar, 8'h62, 8'h01, dtxt_pkg::SepChar,
               8'h04, dtxt_pkg::SepChar, 8'hFF, 8'h00, 8'h7F};
    send_blob();
  endtask

  task automatic test_malformed_pairs();
    // Zero length byte.
    blob_q = '{8'h00, 8'h78, 8'h79};
    send_blob();
    // Key runs to the end of the pair with no separator.
    blob_q = '{8'h02, 8'h61, 8'h62, 8'h7A};
    send_blob();
    // Blob ends inside a value.
    blob_q = '{8'h05, 8'h6B, dtxt_pkg::SepChar, 8'h76};
    send_blob();
    // Blob ends on a length byte after a complete pair.
    blob_q = '{8'h01, dtxt_pkg::SepChar, 8'hFF};
    send_blob();
  endtask

  task automatic test_pair_limit();
    for (int i = 0; i < int'(dtxt_pkg::MaxPairs); i++) begin
      if (i % 40 == 0) add_pair($urandom_range(1, 3), $urandom_range(1, 3));
      else add_pair(0, 0);
    end
    // The next length byte is one pair too many; the rest is ignored.
    blob_q.push_back(8'h05);
    blob_q.push_back(8'h41);
    blob_q.push_back(dtxt_pkg::SepChar);
    send_blob();
    add_pair(1, 1);
    send_blob();
  endtask

  task automatic test_output_stall();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req = 80;
    repeat (4) begin
      add_pair(3, 4);
      add_pair(0, 2);
      send_blob();
    end
  endtask

  task automatic test_random_blobs();
    int unsigned stop_at;
    int sel;
    int len;
    stop_at = parsed_items + RandomItems;
    while (parsed_items < stop_at) begin
      tx_idle_en = ($urandom_range(0, 9) < 7);
      rx_idle_en = ($urandom_range(0, 9) < 7);
      sel = $urandom_range(0, 99);
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 49) == 0) add_pair($urandom_range(0, 120), $urandom_range(0, 134));
        else add_pair($urandom_range(0, 8), $urandom_range(0, 8));
      end
      if (sel >= 96) begin
        blob_q.delete();
        repeat ($urandom_range(1, 20)) blob_q.push_back(ByteW'($urandom_range(0, 255)));
      end else if (sel >= 92) begin
        blob_q.push_back(8'h00);
        add_pair($urandom_range(0, 4), $urandom_range(0, 4));
      end else if (sel >= 86) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 10);
        blob_q.push_back(ByteW'(len));
        repeat (len) blob_q.push_back(rand_key_byte());
        add_pair($urandom_range(0, 4), $urandom_range(0, 4));
      end else if (sel >= 80) begin
        len = $urandom_range(1, blob_q.size() - 1);
        while (blob_q.size() > len) void'(blob_q.pop_back());
      end else if (sel >= 75) begin
        blob_q = '{ByteW'($urandom_range(0, 255))};
      end
      send_blob();
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    rst_ni          = 1'b0;
    reset_parse_state();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_single_byte_blobs();
    test_well_formed_pairs();
    test_malformed_pairs();
    test_pair_limit();
    test_output_stall();
    test_random_blobs();

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/dtxt_pkg.sv
design/dtxt_in_if.sv
design/dtxt_out_if.sv
design/dns_txt_record_parser.sv
bench/tb_dns_txt_record_parser.sv
